[hdl/wmws_pkg.sv]
// package for the weight matrix window scorer
// shared types and constants; no dependencies
package wmws_pkg;

    localparam int MAX_WINDOW_DEF   = 32;
    localparam int SYMBOL_COUNT_DEF = 5;

    localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [2:0] REG_FOCUS_OFFSET  = 3'd1;
    localparam logic [2:0] REG_SCORE_OFFSET  = 3'd2;
    localparam logic [2:0] REG_FIRST_POS     = 3'd3;
    localparam logic [2:0] REG_LAST_POS      = 3'd4;

    typedef struct packed {
        logic               mode;
        logic               new_sequence;
        logic [2:0]         symbol_code;
        logic [7:0]         weight_index;
        logic signed [15:0] weight_value;
        logic               weight_forbidden;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        scored_position;
        logic signed [31:0] window_score;
        logic               score_forbidden;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept;  // take input item
        logic clear;   // clear accumulator, start column walk
        logic step;    // add one column
        logic finish;  // form result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;       // window full, result due
        logic last_col;
    } dp_stat_t;

endpackage

[hdl/weight_matrix_window_scorer.sv]
// Position weight matrix window scorer, top level.
// Input channel (in_valid/in_stall/in_item): load items (mode 0) write one
// weight memory entry; symbol items (mode 1) shift the symbol window. A
// symbol item that fills the window starts a column walk over the weight
// memory, one column per cycle through its single read port; in_stall is
// high for the whole walk. Items that give no result do not stall the input.
// A result appears on out_valid/out_item after the walk and holds until taken.
// A waiting result does not block the next item unless a second result would
// need the output register, in which case in_stall rises until it drains.
// Configuration is to be written through the apb-style port while idle;
// the block itself does not enforce this.
// Reset clears the window, position count, registers and handshakes; the
// weight memory keeps no reset and must be loaded before scoring.
// Depends on wmws_pkg, wmws_regs, wmws_ctrl, wmws_datapath.
module weight_matrix_window_scorer #(
    parameter int MAX_WINDOW   = wmws_pkg::MAX_WINDOW_DEF,
    parameter int SYMBOL_COUNT = wmws_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wmws_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output wmws_pkg::out_item_t out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import wmws_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [5:0]         window_length;
    logic [4:0]         focus_offset;
    logic signed [31:0] score_offset;
    logic [31:0]        first_valid_position;
    logic [31:0]        last_valid_position;

    wmws_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .window_length, .focus_offset, .score_offset,
        .first_valid_position, .last_valid_position
    );

    wmws_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
    );

    wmws_datapath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_dp (
        .clk, .rst_n, .in_item, .cmd, .stat,
        .window_length, .focus_offset, .score_offset,
        .first_valid_position, .last_valid_position,
        .result (out_item)
    );

endmodule

[hdl/wmws_datapath.sv]
// datapath: symbol window, weight memory, column accumulator, result register
// depends on wmws_pkg
module wmws_datapath #(
    parameter int MAX_WINDOW   = 32,
    parameter int SYMBOL_COUNT = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wmws_pkg::in_item_t  in_item,
    input  wmws_pkg::dp_cmd_t   cmd,
    output wmws_pkg::dp_stat_t  stat,
    input  logic [5:0]          window_length,
    input  logic [4:0]          focus_offset,
    input  logic signed [31:0]  score_offset,
    input  logic [31:0]         first_valid_position,
    input  logic [31:0]         last_valid_position,
    output wmws_pkg::out_item_t result
);
    import wmws_pkg::*;

    localparam int DEPTH = MAX_WINDOW * SYMBOL_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW    = $clog2(MAX_WINDOW + 1);

    logic [2:0]  win_reg [MAX_WINDOW];
    logic [16:0] wmem [DEPTH];
    logic [FW-1:0] fill_reg;
    logic [31:0] count_reg;
    logic [CW-1:0] col_reg;
    logic [CW:0]   len_w;
    logic [CW-1:0] lastc;
    logic [AW-1:0] rd_addr;
    logic [16:0]   rd_reg;
    logic          rd_val_reg;
    logic signed [47:0] sum_reg;
    logic          forb_reg;
    logic [31:0]   pos_reg;
    logic [2:0]    code;
    logic [FW-1:0] fill_new;
    logic [2:0]    sym;
    logic signed [47:0] tot;
    logic [31:0]   pos_calc;

    always_comb
    begin
        if (window_length == 6'd0)
            len_w = (CW+1)'(1);
        else if (32'(window_length) > 32'(MAX_WINDOW))
            len_w = (CW+1)'(MAX_WINDOW);
        else
            len_w = (CW+1)'(window_length);
        lastc = CW'(len_w - 1'b1);
        code = (32'(in_item.symbol_code) > 32'(SYMBOL_COUNT - 1))
            ? 3'(SYMBOL_COUNT - 1) : in_item.symbol_code;
        fill_new = in_item.new_sequence ? FW'(0) : fill_reg;
        if (32'(fill_new) < 32'(MAX_WINDOW))
            fill_new = fill_new + 1'b1;
        // column i reads window tap len-1-i
        sym = win_reg[CW'(lastc - col_reg)];
        rd_addr = AW'(32'(col_reg) * SYMBOL_COUNT + 32'(sym));
        stat.emit     = in_item.mode && (32'(fill_new) >= 32'(len_w));
        stat.last_col = (col_reg == lastc);
        tot = sum_reg + 48'(score_offset);
        pos_calc = count_reg - 32'(len_w) + 32'(focus_offset);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_WINDOW; i++)
                win_reg[i] <= 3'd0;
        end
        else if (cmd.accept && in_item.mode)
        begin
            fill_reg  <= fill_new;
            count_reg <= (in_item.new_sequence ? 32'd0 : count_reg) + 32'd1;
            for (int i = 1; i < MAX_WINDOW; i++)
                win_reg[i] <= in_item.new_sequence ? 3'd0 : win_reg[i-1];
            win_reg[0] <= code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !in_item.mode && 32'(in_item.weight_index) < DEPTH)
            wmem[AW'(in_item.weight_index)] <=
                {in_item.weight_forbidden, in_item.weight_value};
        rd_reg <= wmem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            col_reg    <= '0;
            sum_reg    <= '0;
            rd_val_reg <= 1'b0;
            pos_reg    <= pos_calc;
            forb_reg   <= (pos_calc < first_valid_position)
                       || (pos_calc > last_valid_position);
        end
        else
        begin
            if (cmd.step)
                col_reg <= col_reg + 1'b1;
            rd_val_reg <= cmd.step;
            if (rd_val_reg)
            begin
                sum_reg  <= sum_reg + 48'(signed'(rd_reg[15:0]));
                forb_reg <= forb_reg | rd_reg[16];
            end
        end
        if (cmd.finish)
        begin
            result.scored_position <= pos_reg;
            result.score_forbidden <= forb_reg;
            if (forb_reg)
                result.window_score <= '0;
            else if (tot > 48'sh7FFFFFFF)
                result.window_score <= 32'sh7FFFFFFF;
            else if (tot < -48'sh80000000)
                result.window_score <= 32'sh80000000;
            else
                result.window_score <= 32'(tot);
        end
    end

endmodule

[hdl/wmws_ctrl.sv]
// controller: sequences accept, column walk and output handshake
// depends on wmws_pkg
module wmws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  wmws_pkg::dp_stat_t stat,
    output wmws_pkg::dp_cmd_t  cmd
);
    import wmws_pkg::*;

    typedef enum logic [2:0] {IDLE, WALK, DRAIN, LAST, DONE} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // a finished result may wait while the next item is accepted
    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.accept = 1'b1;
                    if (stat.emit)
                        state_next = WALK;
                end
            end
            WALK:
            begin
                // this state loads position and clears the accumulator
                cmd.clear  = 1'b1;
                state_next = DRAIN;
            end
            DRAIN:
            begin
                cmd.step = 1'b1;
                if (stat.last_col)
                    state_next = LAST;
            end
            LAST:
            begin
                // last weight read lands this cycle; accumulate it
                state_next = DONE;
            end
            DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/wmws_regs.sv]
// configuration register file behind an apb-style port
// depends on wmws_pkg
module wmws_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [5:0]         window_length,
    output logic [4:0]         focus_offset,
    output logic signed [31:0] score_offset,
    output logic [31:0]        first_valid_position,
    output logic [31:0]        last_valid_position
);
    import wmws_pkg::*;

    logic [2:0] sel;

    assign pready = 1'b1;
    assign sel    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length        <= 6'd1;
            focus_offset         <= 5'd0;
            score_offset         <= 32'sd0;
            first_valid_position <= 32'd0;
            last_valid_position  <= 32'hFFFFFFFF;
        end
        else if (psel && penable && pwrite)
        begin
            case (sel)
                REG_WINDOW_LENGTH: window_length        <= pwdata[5:0];
                REG_FOCUS_OFFSET:  focus_offset         <= pwdata[4:0];
                REG_SCORE_OFFSET:  score_offset         <= pwdata;
                REG_FIRST_POS:     first_valid_position <= pwdata;
                REG_LAST_POS:      last_valid_position  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_WINDOW_LENGTH: prdata = {26'd0, window_length};
            REG_FOCUS_OFFSET:  prdata = {27'd0, focus_offset};
            REG_SCORE_OFFSET:  prdata = score_offset;
            REG_FIRST_POS:     prdata = first_valid_position;
            REG_LAST_POS:      prdata = last_valid_position;
            default:           prdata = 32'd0;
        endcase
    end

endmodule

[dv/weight_matrix_window_scorer_tb.sv]
// testbench for the weight matrix window scorer
// self-checking: clocked driver and monitor, built-in score predictor
// depends on wmws_pkg and weight_matrix_window_scorer
`timescale 1ns / 100ps

module weight_matrix_window_scorer_tb;
    import wmws_pkg::*;

    localparam int WIN       = MAX_WINDOW_DEF;
    localparam int NSYM      = SYMBOL_COUNT_DEF;
    localparam int DEPTH     = WIN * NSYM;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = WIN + 8;
    localparam int FILL_RAND = 0;
    localparam int FILL_MAX  = 1;
    localparam int FILL_MIN  = 2;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_item_t            in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    weight_matrix_window_scorer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [2:0]         win_sym [WIN];
    logic [16:0]        wtab [DEPTH];
    logic [31:0]        sym_cnt;
    logic [31:0]        fill_lvl;
    logic [5:0]         cfg_len;
    logic [4:0]         cfg_focus;
    logic signed [31:0] cfg_offset;
    logic [31:0]        cfg_first;
    logic [31:0]        cfg_last;

    in_item_t  item_q [$];
    out_item_t score_q [$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    int        gap_left = 0;
    int        stall_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void predict_score(in_item_t it);
        int          len;
        logic [31:0] pos;
        longint      acc;
        bit          forb;
        logic [2:0]  code;
        logic [16:0] entry;
        out_item_t   r;
        if (!it.mode)
        begin
            if (it.weight_index < DEPTH)
                wtab[it.weight_index] = {it.weight_forbidden, it.weight_value};
            return;
        end
        if (it.new_sequence)
        begin
            for (int i = 0; i < WIN; i++) win_sym[i] = '0;
            sym_cnt = '0;
            fill_lvl = '0;
        end
        code = (it.symbol_code > NSYM - 1) ? 3'(NSYM - 1) : it.symbol_code;
        for (int i = WIN - 1; i > 0; i--) win_sym[i] = win_sym[i-1];
        win_sym[0] = code;
        pos = sym_cnt;
        sym_cnt = sym_cnt + 1;
        if (fill_lvl < WIN) fill_lvl = fill_lvl + 1;
        len = (cfg_len == 0) ? 1 : (cfg_len > WIN) ? WIN : int'(cfg_len);
        if (fill_lvl < len) return;
        pos = pos - 32'(len) + 32'd1 + 32'(cfg_focus);
        forb = (pos < cfg_first) || (pos > cfg_last);
        acc = 0;
        if (!forb)
        begin
            for (int i = 0; i < len; i++)
            begin
                entry = wtab[i * NSYM + int'(win_sym[len-1-i])];
                if (entry[16])
                begin
                    forb = 1'b1;
                    break;
                end
                acc += longint'($signed(entry[15:0]));
            end
        end
        if (forb) acc = 0;
        else
        begin
            acc += longint'(cfg_offset);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        end
        r.scored_position = pos;
        r.window_score    = acc[31:0];
        r.score_forbidden = forb;
        score_q.push_back(r);
    endfunction

    function automatic bit drained();
        return item_q.size() == 0 && !in_valid && score_q.size() == 0;
    endfunction

    function automatic in_item_t mk_load(int idx, logic [15:0] w, bit forb);
        in_item_t it;
        it.mode             = 1'b0;
        it.new_sequence     = 1'($urandom);
        it.symbol_code      = 3'($urandom);
        it.weight_index     = 8'(idx);
        it.weight_value     = w;
        it.weight_forbidden = forb;
        return it;
    endfunction

    function automatic in_item_t mk_sym(bit ns, int code);
        in_item_t it;
        it.mode             = 1'b1;
        it.new_sequence     = ns;
        it.symbol_code      = 3'(code);
        it.weight_index     = 8'($urandom);
        it.weight_value     = 16'($urandom);
        it.weight_forbidden = 1'($urandom);
        return it;
    endfunction

    // driver: one nonblocking update per signal per edge
    always @(posedge clk or negedge rst_n)
    begin
        bit       nv;
        in_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            nv  = in_valid;
            nxt = in_item;
            if (in_valid && !in_stall)
            begin
                predict_score(in_item);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0) gap_left--;
                else if (item_q.size() != 0)
                begin
                    if (!quiet && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(0, 4);
                    else
                    begin
                        nxt = item_q.pop_front();
                        nv  = 1'b1;
                    end
                end
            end
            in_valid <= nv;
            in_item  <= nxt;
        end
    end

    // monitor and output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (score_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result %p", $time, out_item);
                end
                else
                begin
                    exp_r = score_q.pop_front();
                    if (out_item.scored_position !== exp_r.scored_position)
                    begin
                        errors++;
                        $display("%0t scored_position exp %0d got %0d", $time,
                                 exp_r.scored_position, out_item.scored_position);
                    end
                    if (out_item.window_score !== exp_r.window_score)
                    begin
                        errors++;
                        $display("%0t window_score exp %0d got %0d", $time,
                                 exp_r.window_score, out_item.window_score);
                    end
                    if (out_item.score_forbidden !== exp_r.score_forbidden)
                    begin
                        errors++;
                        $display("%0t score_forbidden exp %0b got %0b", $time,
                                 exp_r.score_forbidden, out_item.score_forbidden);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] d);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // writes all registers once the block has gone idle
    task automatic set_cfg(logic [5:0] len, logic [4:0] focus, logic [31:0] offs,
                           logic [31:0] first, logic [31:0] last);
        while (!drained()) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        apb_write(REG_WINDOW_LENGTH, 32'(len));
        apb_write(REG_FOCUS_OFFSET, 32'(focus));
        apb_write(REG_SCORE_OFFSET, offs);
        apb_write(REG_FIRST_POS, first);
        apb_write(REG_LAST_POS, last);
        cfg_len    = len;
        cfg_focus  = focus;
        cfg_offset = offs;
        cfg_first  = first;
        cfg_last   = last;
    endtask

    task automatic load_table(int kind, int forb_odds);
        logic [15:0] w;
        for (int i = 0; i < DEPTH; i++)
        begin
            w = (kind == FILL_MAX) ? 16'h7fff : (kind == FILL_MIN) ? 16'h8000 : 16'($urandom);
            item_q.push_back(mk_load(i, w, forb_odds != 0 && $urandom_range(1, forb_odds) == 1));
        end
    endtask

    task automatic random_items(int n);
        int r;
        int code;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                item_q.push_back(mk_load($urandom_range(0, 255), 16'($urandom),
                                         $urandom_range(0, 31) == 0));
            end
            else
            begin
                code = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
                item_q.push_back(mk_sym(r < 9, code));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < WIN; i++) win_sym[i] = '0;
        sym_cnt    = '0;
        fill_lvl   = '0;
        cfg_len    = 6'd1;
        cfg_focus  = '0;
        cfg_offset = '0;
        cfg_first  = '0;
        cfg_last   = 32'hffff_ffff;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_cfg(6'd1, 5'd0, 32'd0, 32'd0, 32'hffff_ffff);
        load_table(FILL_RAND, 0);
        // out-of-range index loads are dropped, extreme weights in column 0
        item_q.push_back(mk_load(255, 16'h1234, 1'b1));
        item_q.push_back(mk_load(DEPTH, 16'h4321, 1'b1));
        item_q.push_back(mk_load(0, 16'h7fff, 1'b0));
        item_q.push_back(mk_load(1, 16'h8000, 1'b0));
        item_q.push_back(mk_load(2, 16'hffff, 1'b1));
        item_q.push_back(mk_sym(1'b1, 0));
        for (int c = 0; c < 8; c++) item_q.push_back(mk_sym(1'b0, c));
        item_q.push_back(mk_load(2, 16'h0000, 1'b0));
        item_q.push_back(mk_sym(1'b1, 2));
        item_q.push_back(mk_sym(1'b1, 1));

        // saturation both ways with full window; extreme focus on the high side
        set_cfg(6'd32, 5'd31, 32'h7fff_fff0, 32'd0, 32'hffff_ffff);
        load_table(FILL_MAX, 0);
        item_q.push_back(mk_sym(1'b1, 3));
        random_items(120);
        set_cfg(6'd32, 5'd0, 32'h8000_0000, 32'd0, 32'hffff_ffff);
        load_table(FILL_MIN, 0);
        random_items(120);

        set_cfg(6'd8, 5'd3, -32'sd1000, 32'd10, 32'd40);
        load_table(FILL_RAND, 40);
        random_items(200);
        // zero length and oversize length, continuing the same stream
        set_cfg(6'd0, 5'd2, 32'd77, 32'd0, 32'hffff_ffff);
        random_items(100);
        set_cfg(6'd63, 5'd5, 32'hffff_ff00, 32'd3, 32'hffff_fffe);
        random_items(100);

        for (int p = 0; p < 4; p++)
        begin
            set_cfg(6'($urandom_range(1, 32)), 5'($urandom_range(0, 31)), $urandom,
                    $urandom_range(0, 20),
                    ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : $urandom_range(30, 400));
            if (p == 2) load_table(FILL_RAND, 60);
            random_items(40);
        end

        set_cfg(6'($urandom_range(4, 12)), 5'($urandom_range(0, 31)), $urandom, 32'd0,
                32'hffff_ffff);
        quiet = 1'b1;
        random_items(150);

        while (!drained()) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (score_q.size() != 0) errors++;
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
hdl/wmws_pkg.sv
hdl/wmws_datapath.sv
hdl/wmws_ctrl.sv
hdl/wmws_regs.sv
hdl/weight_matrix_window_scorer.sv
dv/weight_matrix_window_scorer_tb.sv
